[rtl/biq_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, register indexes and lane control type for the biquad filter.
package biq_pkg;

    localparam int AXES_DEF           = 3;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Q3.F coefficients: sign, three integer bits, F fraction bits
    localparam int COEF_INT_BITS = 4;
    localparam int NUM_COEFS     = 5;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [CFG_INDEX_W-1:0] COEF_B0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] COEF_B1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] COEF_B2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] COEF_A1 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] COEF_A2 = 3'd4;

    // Stage enables shared by all lanes
    typedef struct packed {
        logic load;   // accept a word into the product stage
        logic adv2;   // move products into the feedforward sum
        logic fire;   // close the feedback loop and emit the output
    } biq_ctrl_t;

endpackage

[rtl/biq_coef_regs.sv]
`timescale 1ns / 1ps
// Coefficient register file written through the configuration port.
module biq_coef_regs
    import biq_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int COEF_BITS = COEF_FRAC_BITS + COEF_INT_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [CFG_INDEX_W-1:0]      wr_index,
    input  logic [COEF_BITS-1:0]        wr_data,
    output logic signed [COEF_BITS-1:0] coef [NUM_COEFS]
);

    localparam logic signed [COEF_BITS-1:0] COEF_ONE =
        {{(COEF_INT_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};

    logic signed [COEF_BITS-1:0] coef_reg [NUM_COEFS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                if (i == int'(COEF_B0))
                begin
                    coef_reg[i] <= COEF_ONE;
                end
                else
                begin
                    coef_reg[i] <= '0;
                end
            end
        end
        else if (wr_en)
        begin
            case (wr_index)
                COEF_B0, COEF_B1, COEF_B2, COEF_A1, COEF_A2:
                    coef_reg[wr_index] <= wr_data;
                default:
                    ; // drop writes to unknown indexes
            endcase
        end
    end

    assign coef = coef_reg;

endmodule

[rtl/biq_lane.sv]
`timescale 1ns / 1ps
// One axis biquad section: product stage, feedforward sum and feedback loop.
module biq_lane
    import biq_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int COEF_BITS = COEF_FRAC_BITS + COEF_INT_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  biq_ctrl_t                     ctrl,
    input  logic signed [COEF_BITS-1:0]   coef [NUM_COEFS],
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    output logic signed [SAMPLE_BITS-1:0] y_out
);

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + 4;

    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // input and output history
    logic signed [SAMPLE_BITS-1:0] x1_reg, x2_reg, y1_reg, y2_reg;

    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [PROD_W-1:0] p0_next, p1_next, p2_next;
    logic signed [ACC_W-1:0]  ff_reg, ff_next;
    logic signed [PROD_W-1:0] a2y2_reg, a2y2_next;
    logic signed [PROD_W-1:0] a1y1;
    logic signed [ACC_W-1:0]  acc_sum, acc_q;

    always_comb
    begin
        p0_next = coef[COEF_B0] * x_in;
        p1_next = coef[COEF_B1] * x1_reg;
        p2_next = coef[COEF_B2] * x2_reg;
        ff_next = ACC_W'(p0_reg) + ACC_W'(p1_reg) + ACC_W'(p2_reg);
    end

    // keep a2*y2 current every cycle so a coefficient write is picked up
    always_comb
    begin
        if (ctrl.fire)
        begin
            a2y2_next = coef[COEF_A2] * y1_reg;
        end
        else
        begin
            a2y2_next = coef[COEF_A2] * y2_reg;
        end
    end

    always_comb
    begin
        a1y1    = coef[COEF_A1] * y1_reg;
        acc_sum = ff_reg - ACC_W'(a1y1) - ACC_W'(a2y2_reg) + ROUND_HALF;
        acc_q   = acc_sum >>> COEF_FRAC_BITS;
        if (!acc_q[ACC_W-1] && (|acc_q[ACC_W-2:SAMPLE_BITS-1]))
        begin
            y_out = SAT_MAX;
        end
        else if (acc_q[ACC_W-1] && !(&acc_q[ACC_W-2:SAMPLE_BITS-1]))
        begin
            y_out = SAT_MIN;
        end
        else
        begin
            y_out = acc_q[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg   <= '0;
            x2_reg   <= '0;
            y1_reg   <= '0;
            y2_reg   <= '0;
            a2y2_reg <= '0;
        end
        else
        begin
            a2y2_reg <= a2y2_next;
            if (ctrl.load)
            begin
                x1_reg <= x_in;
                x2_reg <= x1_reg;
            end
            if (ctrl.fire)
            begin
                y1_reg <= y_out;
                y2_reg <= y1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (ctrl.adv2)
        begin
            ff_reg <= ff_next;
        end
    end

endmodule

[rtl/three_axis_biquad_filter.sv]
`timescale 1ns / 1ps
// Top level: stream ports, coefficient registers, axis lanes and output merge.
//
// Each input word carries one signed sample per axis; each axis runs through
// its own direct form 1 biquad with five shared Q3.F coefficients (b0, b1,
// b2, a1, a2; a1 and a2 are subtracted). One output word follows per input.
// Coefficients are written on wr_en/wr_index/wr_data by the user, only while
// idle; the block itself does not enforce this.
// An accepted word moves from the product registers through the feedforward
// sum register into the output register shown on m_axis. Throughput: one word
// per cycle when the receiver does not stall. Each lane has a product stage, a
// feedforward sum stage and a feedback stage; the loop through a1 * y1, the
// three-term add, rounding and saturation is combinational and sets the rate.
//
// Reset clears the filter history and loads b0 = 1.0 with the rest zero,
// which passes samples through. When m_axis_tready is low the output word
// holds; stages behind it still fill, and s_axis_tready drops only once all
// three are full.
module three_axis_biquad_filter
    import biq_pkg::*;
#(
    parameter int AXES           = AXES_DEF,
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int COEF_BITS = COEF_FRAC_BITS + COEF_INT_BITS,
    localparam int FIELD_W   = AXES * SAMPLE_BITS,
    localparam int DATA_W    = ((FIELD_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // sample_x, sample_y, sample_z, ... from bit 0 up, SAMPLE_BITS each
    input  logic [DATA_W-1:0]      s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // filtered_x, filtered_y, filtered_z, ... from bit 0 up, SAMPLE_BITS each
    output logic [DATA_W-1:0]      m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [COEF_BITS-1:0]   wr_data
);

    logic signed [COEF_BITS-1:0]   coef [NUM_COEFS];
    logic signed [SAMPLE_BITS-1:0] lane_y [AXES];

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic ready1, ready2;
    biq_ctrl_t ctrl;

    biq_coef_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .coef     (coef)
    );

    // each stage moves when the one ahead is empty or moving
    always_comb
    begin
        ready2        = !out_valid_reg || m_axis_tready;
        ready1        = !s2_valid_reg || ready2;
        s_axis_tready = !s1_valid_reg || ready1;
        ctrl.load     = s_axis_tvalid && s_axis_tready;
        ctrl.adv2     = s1_valid_reg && ready1;
        ctrl.fire     = s2_valid_reg && ready2;

        s1_valid_next  = ctrl.load || (s1_valid_reg && !ctrl.adv2);
        s2_valid_next  = ctrl.adv2 || (s2_valid_reg && !ctrl.fire);
        out_valid_next = ctrl.fire || (out_valid_reg && !m_axis_tready);
    end

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        biq_lane #(
            .SAMPLE_BITS    (SAMPLE_BITS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .coef  (coef),
            .x_in  (s_axis_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .y_out (lane_y[g])
        );
    end

    // merge lane results into one output word, pad bits zero
    always_comb
    begin
        out_data_next = '0;
        for (int i = 0; i < AXES; i++)
        begin
            out_data_next[i*SAMPLE_BITS +: SAMPLE_BITS] = lane_y[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[rtl/biq_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the biquad filter, bound to the top level.
module biq_checker #(
    parameter int DATA_W = 48
)
(
    input logic              clk,
    input logic              rst_n,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready
);

    // a held output word keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // input stalls only when every stage is full and the output is stalled
    a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while pipeline has room");

    // an accepted word is followed by a valid output word when the receiver does not stall
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
            |=> m_axis_tvalid)
        else $error("accepted word did not reach the output");

endmodule

bind three_axis_biquad_filter biq_checker #(
    .DATA_W (DATA_W)
) u_biq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the three-axis biquad filter: directed and random words checked against a predictor.
module tb_top
    import biq_pkg::*;
();

    localparam int AXES           = AXES_DEF;
    localparam int SAMPLE_BITS    = SAMPLE_BITS_DEF;
    localparam int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF;
    localparam int COEF_BITS      = COEF_FRAC_BITS + COEF_INT_BITS;
    localparam int DATA_W         = ((AXES * SAMPLE_BITS + 7) / 8) * 8;

    localparam int SETTLE_CYCLES = 8;
    localparam int SEG_ITEMS     = 65;

    localparam longint HALF_LSB = longint'(1) <<< (COEF_FRAC_BITS - 1);
    localparam longint OUT_MAX  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN  = -OUT_MAX - 1;

    localparam logic [COEF_BITS-1:0]   COEF_ONE  = COEF_BITS'(1 << COEF_FRAC_BITS);
    localparam logic [COEF_BITS-1:0]   COEF_HALF = COEF_BITS'(1 << (COEF_FRAC_BITS - 1));
    localparam logic [COEF_BITS-1:0]   COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic [COEF_BITS-1:0]   COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic [DATA_W-1:0]      s_axis_tdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [COEF_BITS-1:0]   wr_data;

    int idle_pct  = 0;
    int stall_pct = 0;
    int mism      = 0;

    // expected output words, oldest first
    logic [DATA_W-1:0] filtered_q [$];

    // predictor copy of coefficients and per-axis history
    logic signed [COEF_BITS-1:0]   coef_m [NUM_COEFS];
    logic signed [SAMPLE_BITS-1:0] in_d1  [AXES];
    logic signed [SAMPLE_BITS-1:0] in_d2  [AXES];
    logic signed [SAMPLE_BITS-1:0] out_d1 [AXES];
    logic signed [SAMPLE_BITS-1:0] out_d2 [AXES];

    string field_name [AXES] = '{"filtered_x", "filtered_y", "filtered_z"};

    three_axis_biquad_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Run one word through every axis section and advance the history.
    function automatic logic [DATA_W-1:0] filter_word(input logic [DATA_W-1:0] word);
        logic [DATA_W-1:0]             res;
        logic signed [SAMPLE_BITS-1:0] x;
        longint                        acc;
        longint                        q;
        res = '0;
        for (int a = 0; a < AXES; a++)
        begin
            x = word[a*SAMPLE_BITS +: SAMPLE_BITS];
            acc = longint'(coef_m[COEF_B0]) * longint'(x)
                + longint'(coef_m[COEF_B1]) * longint'(in_d1[a])
                + longint'(coef_m[COEF_B2]) * longint'(in_d2[a])
                - longint'(coef_m[COEF_A1]) * longint'(out_d1[a])
                - longint'(coef_m[COEF_A2]) * longint'(out_d2[a]);
            // round half up, then floor shift
            q = (acc + HALF_LSB) >>> COEF_FRAC_BITS;
            if (q > OUT_MAX)
                q = OUT_MAX;
            if (q < OUT_MIN)
                q = OUT_MIN;
            in_d2[a]  = in_d1[a];
            in_d1[a]  = x;
            out_d2[a] = out_d1[a];
            out_d1[a] = q[SAMPLE_BITS-1:0];
            res[a*SAMPLE_BITS +: SAMPLE_BITS] = q[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] pack_xyz(input logic [SAMPLE_BITS-1:0] x,
                                                   input logic [SAMPLE_BITS-1:0] y,
                                                   input logic [SAMPLE_BITS-1:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return '0;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] rand_coef();
        case ($urandom_range(7))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            default: return COEF_BITS'($urandom);
        endcase
    endfunction

    // within +/-0.5, keeps most outputs out of saturation
    function automatic logic [COEF_BITS-1:0] rand_small_coef();
        return COEF_BITS'(int'($urandom_range(65535)) - 32768);
    endfunction

    // Receiver: stall at the configured rate.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : check_output
        logic [DATA_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (filtered_q.size() == 0)
            begin
                mism++;
                $error("unexpected output word %h", m_axis_tdata);
            end
            else
            begin
                want = filtered_q.pop_front();
                for (int a = 0; a < AXES; a++)
                begin
                    if (want[a*SAMPLE_BITS +: SAMPLE_BITS]
                        !== m_axis_tdata[a*SAMPLE_BITS +: SAMPLE_BITS])
                    begin
                        mism++;
                        $error("%s: expected %0d, got %0d", field_name[a],
                               $signed(want[a*SAMPLE_BITS +: SAMPLE_BITS]),
                               $signed(m_axis_tdata[a*SAMPLE_BITS +: SAMPLE_BITS]));
                    end
                end
            end
        end
    end

    task automatic send_sample(input logic [DATA_W-1:0] word);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        filtered_q.push_back(filter_word(word));
    endtask

    // Hold off input until every expected word is out and the pipe is empty.
    task automatic wait_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_coef(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [COEF_BITS-1:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        if (idx < NUM_COEFS)
            coef_m[idx] = val;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic load_coefs(input logic [COEF_BITS-1:0] b0, input logic [COEF_BITS-1:0] b1,
                              input logic [COEF_BITS-1:0] b2, input logic [COEF_BITS-1:0] a1,
                              input logic [COEF_BITS-1:0] a2);
        write_coef(COEF_B0, b0);
        write_coef(COEF_B1, b1);
        write_coef(COEF_B2, b2);
        write_coef(COEF_A1, a1);
        write_coef(COEF_A2, a2);
    endtask

    // Reset coefficients pass samples straight through.
    task automatic test_passthrough();
        send_sample(pack_xyz(SMP_MAX, SMP_MIN, '0));
        send_sample(pack_xyz(SMP_MIN, SMP_MAX, 16'hFFFF));
        send_sample(pack_xyz(16'h5555, 16'hAAAA, 16'h0001));
        send_sample(pack_xyz(16'hAAAA, 16'h5555, 16'h8001));
        send_sample(pack_xyz('0, '0, SMP_MAX));
        send_sample(pack_xyz(16'hFFFF, 16'h7FFE, SMP_MIN));
    endtask

    task automatic test_saturation();
        wait_results();
        load_coefs(COEF_MAX, '0, '0, '0, '0);
        send_sample(pack_xyz(SMP_MAX, SMP_MIN, 16'd4096));
        send_sample(pack_xyz(SMP_MIN, 16'd4095, 16'hF000));
        wait_results();
        write_coef(COEF_B0, COEF_MIN);
        send_sample(pack_xyz(SMP_MIN, SMP_MAX, 16'd4096));
        send_sample(pack_xyz(16'hF001, 16'hF000, 16'd1));
    endtask

    // b0 = 0.5 puts odd inputs exactly on a half.
    task automatic test_rounding_ties();
        wait_results();
        load_coefs(COEF_HALF, '0, '0, '0, '0);
        send_sample(pack_xyz(16'd1, 16'hFFFF, 16'd3));
        send_sample(pack_xyz(16'hFFFD, SMP_MAX, SMP_MIN));
    endtask

    // y = x + y1: the clipped output must be what feeds back.
    task automatic test_feedback_clip();
        wait_results();
        load_coefs(COEF_ONE, '0, '0, -COEF_ONE, '0);
        send_sample(pack_xyz(16'd30000, 16'hA000, 16'd1));
        send_sample(pack_xyz(16'd30000, 16'hA000, 16'd1));
        send_sample(pack_xyz('0, '0, SMP_MIN));
    endtask

    task automatic test_unmapped_index();
        wait_results();
        load_coefs(COEF_HALF + (COEF_HALF >> 1), COEF_HALF >> 1, '0, '0, '0);
        for (int idx = NUM_COEFS; idx < (1 << CFG_INDEX_W); idx++)
            write_coef(CFG_INDEX_W'(idx), COEF_BITS'($urandom));
        send_sample(pack_xyz(16'd1000, 16'hFC18, SMP_MAX));
        send_sample(pack_xyz(16'd2000, SMP_MIN, 16'd7));
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_results();
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                wait_results();
                case (seg)
                    // Butterworth low-pass near a tenth of the sample rate
                    0: load_coefs(COEF_BITS'(4421), COEF_BITS'(8842), COEF_BITS'(4421),
                                  COEF_BITS'(-74906), COEF_BITS'(27053));
                    // notch at an eighth of the sample rate
                    1: load_coefs(COEF_ONE, COEF_BITS'(-92682), COEF_ONE,
                                  COEF_BITS'(-83414), COEF_BITS'(53084));
                    2: load_coefs(rand_coef(), rand_coef(), rand_coef(),
                                  rand_coef(), rand_coef());
                    default: load_coefs(rand_small_coef(), rand_small_coef(),
                                        rand_small_coef(), rand_small_coef(),
                                        rand_small_coef());
                endcase
                for (int n = 0; n < SEG_ITEMS; n++)
                begin
                    if (n == SEG_ITEMS / 2)
                        wait_results();
                    send_sample(pack_xyz(rand_sample(), rand_sample(), rand_sample()));
                end
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        wr_en         = 1'b0;
        wr_index      = '0;
        wr_data       = '0;
        for (int i = 0; i < NUM_COEFS; i++)
            coef_m[i] = '0;
        coef_m[COEF_B0] = COEF_ONE;
        for (int a = 0; a < AXES; a++)
        begin
            in_d1[a]  = '0;
            in_d2[a]  = '0;
            out_d1[a] = '0;
            out_d2[a] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_passthrough();
        test_saturation();
        test_rounding_ties();
        test_feedback_clip();
        test_unmapped_index();
        test_random_stream();

        wait_results();
        if (mism == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/biq_pkg.sv
rtl/biq_coef_regs.sv
rtl/biq_lane.sv
rtl/three_axis_biquad_filter.sv
rtl/biq_checker.sv
sim/tb_top.sv
